// File: hw/rtl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg: shared types and constants of the dotted line rasterizer
// Command codes, dash pattern constants and the step direction struct.
// ----------------------------------------------------------------------------
package dlr_pkg;

  // Command codes carried on in_command
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Dash pattern: DASH_ON pixels drawn out of every DASH_PERIOD
  localparam int DASH_PERIOD = 4;
  localparam int DASH_ON     = 2;
  localparam int PHASE_BITS  = $clog2(DASH_PERIOD);

  typedef logic [PHASE_BITS-1:0] dlr_phase_t;

  // Step directions of the walk, set on load
  typedef struct packed {
    logic step_x_negative;
    logic step_y_negative;
  } dlr_dir_t;

endpackage

// File: hw/rtl/dlr_setup.sv
// ----------------------------------------------------------------------------
// dlr_setup: line setup
// Derive absolute deltas, step directions and the initial error term.
// ----------------------------------------------------------------------------
module dlr_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic        [COORD_BITS-1:0] delta_x_abs,
  output logic signed [COORD_BITS:0]   delta_y_neg,
  output dlr_pkg::dlr_dir_t            dir,
  output logic signed [COORD_BITS+1:0] error_term
);

  logic signed [COORD_BITS:0]   x0_w, y0_w, x1_w, y1_w;
  logic signed [COORD_BITS:0]   ddx, ddy, ddx_abs;
  logic signed [COORD_BITS+1:0] dx_ext, dy_ext;

  assign x0_w = {start_x[COORD_BITS-1], start_x};
  assign y0_w = {start_y[COORD_BITS-1], start_y};
  assign x1_w = {end_x[COORD_BITS-1], end_x};
  assign y1_w = {end_y[COORD_BITS-1], end_y};

  assign ddx = x1_w - x0_w;
  assign ddy = y1_w - y0_w;

  // Magnitude of a signed difference of two coordinates fits unsigned
  assign ddx_abs     = ddx[COORD_BITS] ? -ddx : ddx;
  assign delta_x_abs = ddx_abs[COORD_BITS-1:0];
  assign delta_y_neg = ddy[COORD_BITS] ? ddy : -ddy;

  assign dir.step_x_negative = !(start_x < end_x);
  assign dir.step_y_negative = !(start_y < end_y);

  assign dx_ext     = {2'b00, delta_x_abs};
  assign dy_ext     = {delta_y_neg[COORD_BITS], delta_y_neg};
  assign error_term = dx_ext + dy_ext;

endmodule

// File: hw/rtl/dlr_step.sv
// ----------------------------------------------------------------------------
// dlr_step: one Bresenham step
// Compare the doubled error against both deltas and advance x and/or y.
// ----------------------------------------------------------------------------
module dlr_step #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] cur_x,
  input  logic signed [COORD_BITS-1:0] cur_y,
  input  logic        [COORD_BITS-1:0] delta_x_abs,
  input  logic signed [COORD_BITS:0]   delta_y_neg,
  input  dlr_pkg::dlr_dir_t            dir,
  input  logic signed [COORD_BITS+1:0] error_term,
  output logic signed [COORD_BITS-1:0] cur_x_nxt,
  output logic signed [COORD_BITS-1:0] cur_y_nxt,
  output logic signed [COORD_BITS+1:0] error_term_nxt
);

  localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

  logic signed [COORD_BITS+2:0] e2, dx_ext, dy_ext, err_ext, err_sum;
  logic                         move_x, move_y;

  assign e2      = {error_term, 1'b0};
  assign dx_ext  = {3'b000, delta_x_abs};
  assign dy_ext  = {{2{delta_y_neg[COORD_BITS]}}, delta_y_neg};
  assign err_ext = {error_term[COORD_BITS+1], error_term};

  assign move_x = (e2 >= dy_ext);
  assign move_y = (e2 <= dx_ext);

  assign err_sum = err_ext
                 + (move_x ? dy_ext : '0)
                 + (move_y ? dx_ext : '0);
  assign error_term_nxt = err_sum[COORD_BITS+1:0];

  always_comb begin
    cur_x_nxt = cur_x;
    cur_y_nxt = cur_y;
    if (move_x) begin
      cur_x_nxt = dir.step_x_negative ? cur_x - ONE : cur_x + ONE;
    end
    if (move_y) begin
      cur_y_nxt = dir.step_y_negative ? cur_y - ONE : cur_y + ONE;
    end
  end

endmodule

// File: hw/rtl/dotted_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// dotted_line_rasterizer_top: dashed all-octant Bresenham line walker
// Path: a command lands in the command register; its pixel is offered on out_valid from the result register.
// Throughput: one command per cycle; in_ready falls only on output stall.
// Reset: synchronous active-low rst_n empties both stages and drops the line.
// ----------------------------------------------------------------------------
module dotted_line_rasterizer_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic        [15:0]           in_line_color,
  // pixel channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_pixel_on,
  output logic        [15:0]           out_pixel_color,
  output logic                         out_last_pixel
);

  // --------------------------------------------------------------------------
  // Stage 1: command register. Every transfer in lands here first; the walk
  // logic works on this copy, so the pixel channel never reaches back to the
  // input ports combinationally except through in_ready.
  // --------------------------------------------------------------------------
  logic                         in_valid_r;
  logic                         cmd_r;
  logic signed [COORD_BITS-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic        [15:0]           color_r;

  // Line state
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, target_x_r, target_y_r;
  logic        [COORD_BITS-1:0] delta_x_abs_r;
  logic signed [COORD_BITS:0]   delta_y_neg_r;
  dlr_pkg::dlr_dir_t            dir_r;
  logic signed [COORD_BITS+1:0] error_term_r;
  dlr_pkg::dlr_phase_t          dash_phase_r;
  logic        [15:0]           held_color_r;
  logic                         line_active_r;

  // Stage 2: result register
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] pixel_x_r, pixel_y_r;
  logic                         pixel_on_r;
  logic        [15:0]           pixel_color_r;
  logic                         last_pixel_r;

  // Setup and step outputs
  logic        [COORD_BITS-1:0] setup_dx;
  logic signed [COORD_BITS:0]   setup_dy_neg;
  dlr_pkg::dlr_dir_t            setup_dir;
  logic signed [COORD_BITS+1:0] setup_err;
  logic signed [COORD_BITS-1:0] step_x, step_y;
  logic signed [COORD_BITS+1:0] step_err;

  logic is_load, emits, out_free, proceed, at_end;

  dlr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_x     (start_x_r),
    .start_y     (start_y_r),
    .end_x       (end_x_r),
    .end_y       (end_y_r),
    .delta_x_abs (setup_dx),
    .delta_y_neg (setup_dy_neg),
    .dir         (setup_dir),
    .error_term  (setup_err)
  );

  dlr_step #(.COORD_BITS(COORD_BITS)) u_step (
    .cur_x          (cur_x_r),
    .cur_y          (cur_y_r),
    .delta_x_abs    (delta_x_abs_r),
    .delta_y_neg    (delta_y_neg_r),
    .dir            (dir_r),
    .error_term     (error_term_r),
    .cur_x_nxt      (step_x),
    .cur_y_nxt      (step_y),
    .error_term_nxt (step_err)
  );

  // --------------------------------------------------------------------------
  // Control. A load, or an advance with no line loaded, produces nothing and
  // always retires. An advance on an active line needs a free result slot:
  // the slot is free when empty or when its pixel transfers out this cycle.
  // --------------------------------------------------------------------------
  assign is_load  = (cmd_r == dlr_pkg::CMD_LOAD);
  assign emits    = in_valid_r && !is_load && line_active_r;
  assign out_free = !out_valid_r || out_ready;
  assign proceed  = in_valid_r && (!emits || out_free);
  assign in_ready = !in_valid_r || proceed;
  assign at_end   = (cur_x_r == target_x_r) && (cur_y_r == target_y_r);

  // Command register: refill when empty or whenever the held command retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r     <= in_command;
      start_x_r <= in_start_x;
      start_y_r <= in_start_y;
      end_x_r   <= in_end_x;
      end_y_r   <= in_end_y;
      color_r   <= in_line_color;
    end
  end

  // Line activity flag: set by load, drop after the endpoint is emitted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
    end else if (proceed) begin
      if (is_load) begin
        line_active_r <= 1'b1;
      end else if (emits && at_end) begin
        line_active_r <= 1'b0;
      end
    end
  end

  // Walk state: latch setup on load, advance one step per emitted pixel short of the endpoint
  always_ff @(posedge clk) begin
    if (proceed && is_load) begin
      cur_x_r       <= start_x_r;
      cur_y_r       <= start_y_r;
      target_x_r    <= end_x_r;
      target_y_r    <= end_y_r;
      delta_x_abs_r <= setup_dx;
      delta_y_neg_r <= setup_dy_neg;
      dir_r         <= setup_dir;
      error_term_r  <= setup_err;
      dash_phase_r  <= '0;
      held_color_r  <= color_r;
    end else if (proceed && emits && !at_end) begin
      cur_x_r       <= step_x;
      cur_y_r       <= step_y;
      error_term_r  <= step_err;
      // Phase counter wraps at the dash period
      dash_phase_r  <= dash_phase_r + dlr_pkg::dlr_phase_t'(1);
    end
  end

  // Result register: hold until the pixel transfers out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed && emits) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && emits) begin
      pixel_x_r     <= cur_x_r;
      pixel_y_r     <= cur_y_r;
      pixel_on_r    <= (dash_phase_r < dlr_pkg::PHASE_BITS'(dlr_pkg::DASH_ON));
      pixel_color_r <= held_color_r;
      last_pixel_r  <= at_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pixel_x_r;
  assign out_pixel_y     = pixel_y_r;
  assign out_pixel_on    = pixel_on_r;
  assign out_pixel_color = pixel_color_r;
  assign out_last_pixel  = last_pixel_r;

`ifndef ASSERT_OFF
  // A retired load leaves an active line at the start of its dash pattern
  assert property (@(posedge clk) disable iff (!rst_n)
    (proceed && is_load) |=> (line_active_r && dash_phase_r == '0))
    else $error("load did not start a fresh line");

  // Emitting the endpoint ends the line
  assert property (@(posedge clk) disable iff (!rst_n)
    (proceed && emits && at_end) |=> !line_active_r)
    else $error("line still active after its endpoint");

  // The command stage stalls only behind a full, blocked result register
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without output backpressure");

  // A pixel enters the result register only from an active line
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(line_active_r))
    else $error("pixel produced with no line loaded");
`endif

endmodule

// File: tb/dotted_line_rasterizer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dotted_line_rasterizer_top_test: self-checking bench of the dashed line walker
// Drives load and advance commands over the valid/ready command channel, runs
// an in-bench Bresenham walk with the 2-on/2-off dash to predict every pixel,
// and compares each pixel transfer field by field. Directed rows come first,
// then random line sequences under four sender/receiver idling phases.
// ----------------------------------------------------------------------------
module dotted_line_rasterizer_top_test;

  localparam int COORD_BITS  = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 200;
  localparam int DRAIN_CYCLES = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One pixel as it leaves the block
  typedef struct packed {
    coord_t      x;
    coord_t      y;
    logic        on;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  // Where the expectation of a command comes from
  typedef enum logic [1:0] {
    GOLD_MODEL, // ask the predictor
    GOLD_NONE,  // typed in: no pixel
    GOLD_PIXEL  // typed in: this pixel
  } golden_kind_t;

  typedef struct packed {
    logic         cmd;
    coord_t       sx;
    coord_t       sy;
    coord_t       ex;
    coord_t       ey;
    logic [15:0]  color;
    golden_kind_t kind;
    pixel_t       gold;
  } stim_row_t;

  localparam pixel_t NO_PIXEL = '0;
  localparam coord_t C_MIN = coord_t'(-2048);
  localparam coord_t C_MAX = coord_t'(2047);
  localparam coord_t C_0   = coord_t'(0);

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // advance right after reset: no line loaded, nothing comes out
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_NONE, NO_PIXEL},
    // zero-length line: one pixel, flagged last, then the line is gone
    '{dlr_pkg::CMD_LOAD, C_0, C_0, C_0, C_0, 16'hFFFF, GOLD_NONE, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_MAX, C_MAX, C_MAX, C_MAX, 16'h0000, GOLD_PIXEL,
      '{C_0, C_0, 1'b1, 16'hFFFF, 1'b1}},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_NONE, NO_PIXEL},
    // corner to corner, rising; walk into the off part of the dash
    '{dlr_pkg::CMD_LOAD, C_MIN, C_MIN, C_MAX, C_MAX, 16'h0000, GOLD_NONE, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'hFFFF, GOLD_PIXEL,
      '{C_MIN, C_MIN, 1'b1, 16'h0000, 1'b0}},
    '{dlr_pkg::CMD_ADVANCE, C_MIN, C_MIN, C_MIN, C_MIN, 16'h0000, GOLD_MODEL,
      NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    // reload mid-line: the old line is dropped
    '{dlr_pkg::CMD_LOAD, C_MAX, C_MIN, C_MIN, C_MAX, 16'hA5A5, GOLD_NONE, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_PIXEL,
      '{C_MAX, C_MIN, 1'b1, 16'hA5A5, 1'b0}},
    // single pixel at the top corner
    '{dlr_pkg::CMD_LOAD, C_MAX, C_MAX, C_MAX, C_MAX, 16'h5A5A, GOLD_NONE, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_PIXEL,
      '{C_MAX, C_MAX, 1'b1, 16'h5A5A, 1'b1}},
    // short horizontal run along the top edge from the left corner, walked past its end
    '{dlr_pkg::CMD_LOAD, C_MIN, C_MAX, coord_t'(-2045), C_MAX, 16'h1234, GOLD_NONE,
      NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    // x-major walk toward negative x and y
    '{dlr_pkg::CMD_LOAD, coord_t'(3), coord_t'(-1), coord_t'(-2), coord_t'(-4),
      16'h8001, GOLD_NONE, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL},
    '{dlr_pkg::CMD_ADVANCE, C_0, C_0, C_0, C_0, 16'h0000, GOLD_MODEL, NO_PIXEL}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  coord_t      in_start_x;
  coord_t      in_start_y;
  coord_t      in_end_x;
  coord_t      in_end_y;
  logic [15:0] in_line_color;
  logic        out_valid;
  logic        out_ready = 1'b0;
  coord_t      out_pixel_x;
  coord_t      out_pixel_y;
  logic        out_pixel_on;
  logic [15:0] out_pixel_color;
  logic        out_last_pixel;

  // Expectation source travels along with the payload of each command
  golden_kind_t cmd_gold_kind;
  pixel_t       cmd_gold_pixel;

  int sender_idle_pct;
  int recv_stall_pct;
  int commands_taken;
  int error_count;
  int cycle_count;

  pixel_t expected_pixels [$];

  // Walk state of the predictor
  coord_t     walk_x, walk_y, goal_x, goal_y;
  logic [COORD_BITS-1:0] run_abs;
  logic signed [COORD_BITS:0] rise_neg;
  logic signed [COORD_BITS+1:0] bres_err;
  dlr_pkg::dlr_dir_t   walk_dir;
  dlr_pkg::dlr_phase_t dash_pos;
  logic [15:0] held_color;
  logic       line_live;

  dotted_line_rasterizer_top #(.COORD_BITS(COORD_BITS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_line_color   (in_line_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_on    (out_pixel_on),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

  always #2 clk = ~clk;

  // Apply one command to the walk; return 1 when it yields a pixel
  function automatic bit rasterize_command(input logic cmd, input coord_t sx, input coord_t sy,
                                           input coord_t ex, input coord_t ey,
                                           input logic [15:0] color, output pixel_t px);
    int dx, dy, err, e2;
    px = '0;
    if (cmd == dlr_pkg::CMD_LOAD) begin
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      walk_x = sx;
      walk_y = sy;
      goal_x = ex;
      goal_y = ey;
      run_abs = COORD_BITS'((dx < 0) ? -dx : dx);
      rise_neg = (COORD_BITS+1)'((dy < 0) ? dy : -dy);
      walk_dir.step_x_negative = !(sx < ex);
      walk_dir.step_y_negative = !(sy < ey);
      bres_err = (COORD_BITS+2)'(((dx < 0) ? -dx : dx) + ((dy < 0) ? dy : -dy));
      dash_pos = '0;
      held_color = color;
      line_live = 1'b1;
      return 1'b0;
    end
    if (!line_live) return 1'b0;
    px.x = walk_x;
    px.y = walk_y;
    px.on = (int'(dash_pos) < dlr_pkg::DASH_ON);
    px.color = held_color;
    px.last = (walk_x == goal_x) && (walk_y == goal_y);
    if (px.last) begin
      line_live = 1'b0;
    end else begin
      err = int'(bres_err);
      e2 = 2 * err;
      if (e2 >= int'(rise_neg)) begin
        err = err + int'(rise_neg);
        walk_x = coord_t'(int'(walk_x) + (walk_dir.step_x_negative ? -1 : 1));
      end
      if (e2 <= int'(run_abs)) begin
        err = err + int'(run_abs);
        walk_y = coord_t'(int'(walk_y) + (walk_dir.step_y_negative ? -1 : 1));
      end
      bres_err = (COORD_BITS+2)'(err);
      dash_pos = dlr_pkg::dlr_phase_t'((int'(dash_pos) + 1) % dlr_pkg::DASH_PERIOD);
    end
    return 1'b1;
  endfunction

  // Hold a command on the channel until it transfers, after a random gap
  task automatic send_command(input logic cmd, input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey, input logic [15:0] color,
                              input golden_kind_t kind, input pixel_t gold);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_start_x     <= sx;
    in_start_y     <= sy;
    in_end_x       <= ex;
    in_end_y       <= ey;
    in_line_color  <= color;
    cmd_gold_kind  <= kind;
    cmd_gold_pixel <= gold;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  function automatic coord_t clamp_coord(input int v);
    if (v < -2048) return C_MIN;
    if (v > 2047) return C_MAX;
    return coord_t'(v);
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom_range(4095));
  endfunction

  // Advance with random (ignored) endpoint fields
  task automatic send_advance();
    send_command(dlr_pkg::CMD_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord(),
                 16'($urandom), GOLD_MODEL, NO_PIXEL);
  endtask

  // Load one random line, then walk it to its end, past it, or abandon it
  task automatic draw_random_line();
    int mode, span, pixels, steps;
    coord_t sx, sy, ex, ey;
    mode = $urandom_range(99);
    sx = any_coord();
    sy = any_coord();
    if (mode < 92) begin
      span = (mode < 80) ? 9 : 60;
      ex = clamp_coord(int'(sx) + int'($urandom_range(2 * span)) - span);
      ey = clamp_coord(int'(sy) + int'($urandom_range(2 * span)) - span);
    end else if (mode < 97) begin
      ex = any_coord();
      ey = any_coord();
    end else begin
      // corners only
      sx = $urandom_range(1) ? C_MAX : C_MIN;
      sy = $urandom_range(1) ? C_MAX : C_MIN;
      ex = $urandom_range(1) ? C_MAX : C_MIN;
      ey = $urandom_range(1) ? C_MAX : C_MIN;
    end
    send_command(dlr_pkg::CMD_LOAD, sx, sy, ex, ey, 16'($urandom), GOLD_NONE, NO_PIXEL);
    pixels = (int'(ex) - int'(sx));
    if (pixels < 0) pixels = -pixels;
    span = int'(ey) - int'(sy);
    if (span < 0) span = -span;
    if (span > pixels) pixels = span;
    pixels = pixels + 1;
    if (pixels > 64) steps = $urandom_range(24, 1);
    else if ($urandom_range(99) < 80) steps = pixels + $urandom_range(2);
    else steps = $urandom_range(pixels);
    repeat (steps) send_advance();
  endtask

  // Receiver: stall at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Predict on each command transfer, check on each pixel transfer
  always @(posedge clk) begin
    pixel_t px, want;
    bit     emitted;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel at x=%0d y=%0d", out_pixel_x, out_pixel_y);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_x !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, out_pixel_x);
            error_count++;
          end
          if (out_pixel_y !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, out_pixel_y);
            error_count++;
          end
          if (out_pixel_on !== want.on) begin
            $error("pixel_on: expected %0b, got %0b", want.on, out_pixel_on);
            error_count++;
          end
          if (out_pixel_color !== want.color) begin
            $error("pixel_color: expected %h, got %h", want.color, out_pixel_color);
            error_count++;
          end
          if (out_last_pixel !== want.last) begin
            $error("last_pixel: expected %0b, got %0b", want.last, out_last_pixel);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        emitted = rasterize_command(in_command, in_start_x, in_start_y, in_end_x, in_end_y,
                                    in_line_color, px);
        // typed-in rows override the predictor; the walk state still advances
        case (cmd_gold_kind)
          GOLD_PIXEL: expected_pixels.push_back(cmd_gold_pixel);
          GOLD_NONE: ;
          default: begin
            if (emitted) expected_pixels.push_back(px);
          end
        endcase
        // count loads and pixel-producing advances only
        if (in_command == dlr_pkg::CMD_LOAD || emitted) commands_taken++;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = dlr_pkg::CMD_LOAD;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x = '0;
    in_end_y = '0;
    in_line_color = '0;
    cmd_gold_kind = GOLD_MODEL;
    cmd_gold_pixel = '0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    commands_taken = 0;
    error_count = 0;
    cycle_count = 0;
    walk_x = '0;
    walk_y = '0;
    goal_x = '0;
    goal_y = '0;
    run_abs = '0;
    rise_neg = '0;
    bres_err = '0;
    walk_dir = '0;
    dash_pos = '0;
    held_color = '0;
    line_live = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows, no idling
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_command(DIRECTED[i].cmd, DIRECTED[i].sx, DIRECTED[i].sy, DIRECTED[i].ex,
                   DIRECTED[i].ey, DIRECTED[i].color, DIRECTED[i].kind, DIRECTED[i].gold);
    end

    // Random lines: no idling, sender idle, receiver stalling, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin sender_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      while (commands_taken < (p + 1) * PHASE_ITEMS) begin
        // some noise: stray advances, which may hit an ended line
        if ($urandom_range(99) < 6) send_advance();
        else draw_random_line();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/dlr_pkg.sv
hw/rtl/dlr_setup.sv
hw/rtl/dlr_step.sv
hw/rtl/dotted_line_rasterizer_top.sv
tb/dotted_line_rasterizer_top_test.sv
